// ===== rtl/text_message_deframer_unit_assert.svh =====
// ----------------------------------------------------------------------------
// text message deframer assertion macros
// Shorthand for the clocked, reset-qualified checks used in the deframer.
// ----------------------------------------------------------------------------
`ifndef TEXT_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH
`define TEXT_MESSAGE_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TMD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define TMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tmd_pkg.sv =====
// ----------------------------------------------------------------------------
// tmd_pkg
// Types, constants and character helpers for the text message deframer.
// ----------------------------------------------------------------------------
package tmd_pkg;

    // header layout
    localparam int HDR_BYTES  = 8;
    localparam int TYPE_BYTES = 4;
    localparam int LEN_W      = 16;
    localparam int HDR_W      = 8 * HDR_BYTES;
    localparam int TYPE_W     = 8 * TYPE_BYTES;
    localparam int HDR_CNT_W  = $clog2(HDR_BYTES);

    // input beat action
    typedef enum logic {
        ACT_BYTE  = 1'b0,
        ACT_FLUSH = 1'b1
    } t_action;

    // result kind
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef struct packed {
        t_action    action;
        logic [7:0] byte_value;
    } t_in_beat;

    typedef struct packed {
        t_kind              kind;
        logic [TYPE_W-1:0]  msg_type;
        logic [LEN_W-1:0]   msg_length;
        logic [7:0]         payload_byte;
        logic               last;
    } t_out_beat;

    // whitespace set stripped around the length field
    function automatic logic is_space(input logic [7:0] c);
        return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20) || (c == 8'h85) ||
               (c == 8'hA0);
    endfunction

    // hex digit decode: {valid, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if ((c >= "0") && (c <= "9")) begin
            d = c - 8'h30;
            return {1'b1, d[3:0]};
        end
        if ((c >= "a") && (c <= "f")) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if ((c >= "A") && (c <= "F")) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

// ===== rtl/tmd_if.sv =====
// ----------------------------------------------------------------------------
// tmd stream interfaces
// Valid/ready channels for stream input beats and deframed result beats.
// ----------------------------------------------------------------------------
interface tmd_in_if import tmd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmd_out_if import tmd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/text_message_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// text_message_deframer_unit
// Splits a byte stream into messages of 4 type bytes, a 4-character hex
// length field and that many payload bytes.
// ----------------------------------------------------------------------------
// Takes one stream byte or flush per clock. Each accepted beat updates the
// header shift register, byte counter and payload countdown in the same
// cycle, and any result is registered into the output register, or into a
// skid register behind it while the output is stalled. The input stalls
// only while both registers are full. The eighth header byte produces a
// header or header-error result; every payload byte produces a payload
// result, the final one marked last.
module text_message_deframer_unit
    import tmd_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tmd_in_if.sink        i_in,
    tmd_out_if.source     o_out
);

    typedef enum logic [1:0] {
        ST_HEADER  = 2'b01,
        ST_PAYLOAD = 2'b10
    } t_state;

    t_state                 r_state, n_state;
    logic [HDR_CNT_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [HDR_W-1:0]       r_hdr, n_hdr;
    logic [LEN_W-1:0]       r_rem, n_rem;
    t_out_beat              r_out, n_out;
    logic                   r_out_valid, n_out_valid;
    t_out_beat              r_skid, n_skid;
    logic                   r_skid_valid, n_skid_valid;

    logic                   in_fire;
    logic                   out_fire;
    logic [HDR_W-1:0]       hdr_full;
    logic                   len_ok;
    logic [LEN_W-1:0]       len_val;
    t_out_beat              res;
    logic                   res_valid;

    // handshakes
    assign i_in.ready  = !r_skid_valid;
    assign in_fire     = i_in.valid && !r_skid_valid;
    assign out_fire    = r_out_valid && o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // header with the incoming byte shifted in
    assign hdr_full = {r_hdr[HDR_W-9:0], i_in.data.byte_value};

    // length field decode: strip outer whitespace, rest must be hex
    always_comb begin
        logic [7:0]            ch   [TYPE_BYTES];
        logic [TYPE_BYTES-1:0] sp;
        logic [TYPE_BYTES-1:0] hx;
        logic [3:0]            dg   [TYPE_BYTES];
        logic [TYPE_BYTES-1:0] lead;
        logic [TYPE_BYTES-1:0] trail;
        logic [4:0]            hd;
        for (int i = 0; i < TYPE_BYTES; i++) begin
            ch[i] = hdr_full[8*(TYPE_BYTES-1-i) +: 8];
            sp[i] = is_space(ch[i]);
            hd    = hex_digit(ch[i]);
            hx[i] = hd[4];
            dg[i] = hd[3:0];
        end
        lead[0] = sp[0];
        for (int i = 1; i < TYPE_BYTES; i++) begin
            lead[i] = lead[i-1] && sp[i];
        end
        trail[TYPE_BYTES-1] = sp[TYPE_BYTES-1];
        for (int i = TYPE_BYTES - 2; i >= 0; i--) begin
            trail[i] = trail[i+1] && sp[i];
        end
        len_ok = !lead[TYPE_BYTES-1];
        for (int i = 0; i < TYPE_BYTES; i++) begin
            len_ok = len_ok && (hx[i] || lead[i] || trail[i]);
        end
        len_val = '0;
        for (int i = 0; i < TYPE_BYTES; i++) begin
            if (!sp[i]) begin
                len_val = {len_val[LEN_W-5:0], dg[i]};
            end
        end
    end

    // parse state and result for the accepted beat
    always_comb begin
        n_state   = r_state;
        n_hdr_cnt = r_hdr_cnt;
        n_hdr     = r_hdr;
        n_rem     = r_rem;
        res_valid = 1'b0;
        res       = '{kind: KIND_HEADER, msg_type: '0, msg_length: '0,
                      payload_byte: '0, last: 1'b0};
        if (in_fire) begin
            if (i_in.data.action == ACT_FLUSH) begin
                n_state   = ST_HEADER;
                n_hdr_cnt = '0;
                n_rem     = '0;
            end else begin
                unique case (r_state)
                    ST_PAYLOAD: begin
                        n_rem            = r_rem - 1'b1;
                        res_valid        = 1'b1;
                        res.kind         = KIND_PAYLOAD;
                        res.msg_type     = r_hdr[HDR_W-1 -: TYPE_W];
                        res.msg_length   = r_hdr[LEN_W-1:0];
                        res.payload_byte = i_in.data.byte_value;
                        res.last         = (r_rem == LEN_W'(1));
                        if (r_rem == LEN_W'(1)) begin
                            n_state   = ST_HEADER;
                            n_hdr_cnt = '0;
                        end
                    end
                    ST_HEADER: begin
                        n_hdr     = hdr_full;
                        n_hdr_cnt = r_hdr_cnt + 1'b1;
                        if (r_hdr_cnt == HDR_CNT_W'(HDR_BYTES - 1)) begin
                            res_valid    = 1'b1;
                            res.msg_type = hdr_full[HDR_W-1 -: TYPE_W];
                            if (len_ok) begin
                                res.kind       = KIND_HEADER;
                                res.msg_length = len_val;
                                res.last       = (len_val == '0);
                                n_hdr[TYPE_W-1:0] = TYPE_W'(len_val);
                                if (len_val != '0) begin
                                    n_state = ST_PAYLOAD;
                                    n_rem   = len_val;
                                end
                            end else begin
                                res.kind = KIND_ERROR;
                                n_hdr    = '0;
                            end
                        end
                    end
                    default: begin
                        n_state = ST_HEADER;
                    end
                endcase
            end
        end
    end

    // output register with skid slot
    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = res;
                n_skid_valid = 1'b1;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_HEADER;
            r_hdr_cnt    <= '0;
            r_rem        <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hdr_cnt    <= n_hdr_cnt;
            r_rem        <= n_rem;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_hdr  <= n_hdr;
        r_out  <= n_out;
        r_skid <= n_skid;
    end

`include "text_message_deframer_unit_assert.svh"

    // skid slot only fills behind a held output beat
    `TMD_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid, "skid without output beat")

    // payload phase always has bytes due and a cleared header count
    `TMD_ASSERT_NOW(a_payload_rem, i_clk, i_rst_n, r_state == ST_PAYLOAD, (r_rem != '0) && (r_hdr_cnt == '0), "payload phase with no bytes due")

    // final payload byte returns to header collection
    `TMD_ASSERT_NEXT(a_last_to_header, i_clk, i_rst_n, in_fire && (i_in.data.action == ACT_BYTE) && (r_state == ST_PAYLOAD) && (r_rem == LEN_W'(1)), (r_state == ST_HEADER) && (r_hdr_cnt == '0), "last payload byte did not end message")

endmodule

// ===== tb/sv/text_message_deframer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// text_message_deframer_unit_tb
// Drives byte and flush beats into the deframer and checks every result beat
// against a deframing predictor kept in step with accepted input beats. The
// stream starts with directed headers and goes on with random messages, bad
// headers, cut-off messages and flushes, under random idling on both sides.
// ----------------------------------------------------------------------------
module text_message_deframer_unit_tb;
    import tmd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int HOLD_CYCLES    = 150;
    localparam int HOLD_AFTER     = 200;
    localparam int DRAIN_CYCLES   = 16;
    localparam int STREAM_BEATS   = 600;

    bit   i_clk;
    logic i_rst_n = 1'b0;

    tmd_in_if  stream_if ();
    tmd_out_if result_if ();

    text_message_deframer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (stream_if),
        .o_out   (result_if)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_in_beat  stream_q[$];
    t_out_beat deframed_q[$];
    int        stream_total;
    int        beats_in;
    int        mismatches;
    int        idle_cycles;
    int        tx_wait;
    int        rx_wait;
    bit        tx_burst;
    bit        rx_burst;
    bit        rx_hold;
    bit        in_taken;
    bit        out_taken;

    // predictor state
    logic        in_body;
    logic [2:0]  hdr_cnt;
    logic [63:0] hdr_sr;
    logic [15:0] body_left;

    initial begin
        in_body   = 1'b0;
        hdr_cnt   = '0;
        hdr_sr    = '0;
        body_left = '0;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    function automatic logic blank(input logic [7:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // {ok, value} for one character
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h41 + 8'd10;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h61 + 8'd10;
        end else begin
            return 5'h00;
        end
        return {1'b1, v[3:0]};
    endfunction

    // {ok, length} from the four length characters, first one highest
    function automatic logic [16:0] decode_length_field(input logic [31:0] field);
        logic [7:0]  ch [4];
        logic [4:0]  nib;
        logic [15:0] acc;
        int          lo;
        int          hi;
        int          k;
        for (k = 0; k < 4; k++) ch[k] = field[8*(3-k) +: 8];
        lo  = 0;
        hi  = 4;
        acc = '0;
        while (lo < 4 && blank(ch[lo])) lo++;
        while (hi > lo && blank(ch[hi-1])) hi--;
        if (lo == hi) return '0;
        for (k = lo; k < hi; k++) begin
            nib = nibble_of(ch[k]);
            if (!nib[4]) return '0;
            acc = {acc[11:0], nib[3:0]};
        end
        return {1'b1, acc};
    endfunction

    // one accepted beat in, expected result (if any) queued
    task automatic deframe_beat(input t_in_beat b);
        t_out_beat   r;
        logic [16:0] dec;
        r = '0;
        if (b.action == ACT_FLUSH) begin
            in_body   = 1'b0;
            hdr_cnt   = '0;
            hdr_sr    = '0;
            body_left = '0;
            return;
        end
        // payload byte
        if (in_body) begin
            body_left      = body_left - 16'd1;
            r.kind         = KIND_PAYLOAD;
            r.msg_type     = hdr_sr[63:32];
            r.msg_length   = hdr_sr[15:0];
            r.payload_byte = b.byte_value;
            r.last         = (body_left == 16'd0);
            if (body_left == 16'd0) begin
                in_body = 1'b0;
                hdr_cnt = '0;
            end
            deframed_q.push_back(r);
            return;
        end
        // header byte
        hdr_sr  = {hdr_sr[55:0], b.byte_value};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt != 3'd0) return;
        dec        = decode_length_field(hdr_sr[31:0]);
        r.msg_type = hdr_sr[63:32];
        if (!dec[16]) begin
            r.kind = KIND_ERROR;
            hdr_sr = '0;
        end else begin
            r.kind       = KIND_HEADER;
            r.msg_length = dec[15:0];
            r.last       = (dec[15:0] == 16'd0);
            hdr_sr       = {r.msg_type, 16'h0000, dec[15:0]};
            if (dec[15:0] != 16'd0) begin
                in_body   = 1'b1;
                body_left = dec[15:0];
            end
        end
        deframed_q.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------------

    task automatic push_beat(input t_action act, input logic [7:0] value);
        t_in_beat b;
        b.action     = act;
        b.byte_value = value;
        stream_q.push_back(b);
    endtask

    task automatic push_header(input logic [31:0] kind_chars, input logic [31:0] field);
        int k;
        for (k = 3; k >= 0; k--) push_beat(ACT_BYTE, kind_chars[8*k +: 8]);
        for (k = 3; k >= 0; k--) push_beat(ACT_BYTE, field[8*k +: 8]);
    endtask

    task automatic push_noise(input int count);
        int k;
        for (k = 0; k < count; k++) push_beat(ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(0, 7);
        if (k < 5) return 8'h09 + 8'(k);
        if (k == 5) return 8'h20;
        if (k == 6) return 8'h85;
        return 8'hA0;
    endfunction

    // hex digit in random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + {4'h0, n};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, n} - 8'd10;
    endfunction

    // well-formed length field: optional leading zeros, random blank padding
    function automatic logic [31:0] length_field(input logic [15:0] len);
        logic [31:0] f;
        int          need;
        int          digits;
        int          lead;
        int          k;
        need = 1;
        for (k = 1; k < 4; k++) if ((len >> (4*k)) != 0) need = k + 1;
        digits = $urandom_range(need, 4);
        lead   = $urandom_range(0, 4 - digits);
        f      = '0;
        for (k = 0; k < 4; k++) begin
            f = f << 8;
            if (k < lead || k >= lead + digits) f[7:0] = blank_char();
            else f[7:0] = hex_char(len[4*(digits-1-(k-lead)) +: 4]);
        end
        return f;
    endfunction

    // malformed length field
    function automatic logic [31:0] bad_field();
        case ($urandom_range(0, 4))
            0: return {hex_char(4'($urandom)), blank_char(), hex_char(4'($urandom)),
                       hex_char(4'($urandom))};
            1: return {($urandom_range(0, 1) ? 8'h2B : 8'h2D), hex_char(4'($urandom)),
                       blank_char(), blank_char()};
            2: return {8'h30, ($urandom_range(0, 1) ? 8'h78 : 8'h58),
                       hex_char(4'($urandom)), hex_char(4'($urandom))};
            3: return {blank_char(), blank_char(), blank_char(), blank_char()};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_message();
        logic [15:0] len;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            // complete message, mostly short
            len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 40))
                                               : 16'($urandom_range(0, 8));
            push_header($urandom, length_field(len));
            push_noise(len);
        end else if (pick < 80) begin
            push_header($urandom, bad_field());
        end else if (pick < 88) begin
            // long message cut off by a flush
            len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(256, 65534));
            push_header($urandom, length_field(len));
            push_noise($urandom_range(0, 6));
            push_beat(ACT_FLUSH, 8'($urandom_range(0, 255)));
        end else if (pick < 95) begin
            // partial header then flush
            push_noise($urandom_range(1, 7));
            push_beat(ACT_FLUSH, 8'($urandom_range(0, 255)));
        end else begin
            push_beat(ACT_FLUSH, 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // monitor: results checked before the same edge's input beat is predicted
    always @(posedge i_clk) begin
        t_out_beat want;
        in_taken  = 1'b0;
        out_taken = 1'b0;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                out_taken = 1'b1;
                if (deframed_q.size() == 0) begin
                    flag_mismatch("result beat with none pending, kind",
                                  32'(result_if.data.kind), 32'h0);
                end else begin
                    want = deframed_q.pop_front();
                    if (result_if.data.kind !== want.kind)
                        flag_mismatch("kind", 32'(result_if.data.kind), 32'(want.kind));
                    if (result_if.data.msg_type !== want.msg_type)
                        flag_mismatch("msg_type", result_if.data.msg_type, want.msg_type);
                    if (result_if.data.msg_length !== want.msg_length)
                        flag_mismatch("msg_length", 32'(result_if.data.msg_length),
                                      32'(want.msg_length));
                    if (result_if.data.payload_byte !== want.payload_byte)
                        flag_mismatch("payload_byte", 32'(result_if.data.payload_byte),
                                      32'(want.payload_byte));
                    if (result_if.data.last !== want.last)
                        flag_mismatch("last", 32'(result_if.data.last), 32'(want.last));
                end
            end
            if (stream_if.valid && stream_if.ready) begin
                in_taken = 1'b1;
                beats_in++;
                deframe_beat(stream_if.data);
            end
        end
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if ((stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("text_message_deframer_unit_tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    // input driver with random gaps and bursts
    always @(negedge i_clk) begin
        logic     nxt_valid;
        t_in_beat nxt_data;
        nxt_valid = stream_if.valid;
        nxt_data  = stream_if.data;
        if (i_rst_n) begin
            if (in_taken) nxt_valid = 1'b0;
            if (!nxt_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (stream_q.size() > 0) begin
                    nxt_data  = stream_q.pop_front();
                    nxt_valid = 1'b1;
                    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                    tx_wait = (tx_burst || rx_hold) ? 0 : $urandom_range(0, 17);
                end
            end
        end
        stream_if.valid <= nxt_valid;
        stream_if.data  <= nxt_data;
    end

    // result receiver with random stalls
    always @(negedge i_clk) begin
        logic nxt_ready;
        if (out_taken) begin
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            rx_wait = rx_burst ? 0 : $urandom_range(0, 17);
        end
        nxt_ready = i_rst_n && !rx_hold && (rx_wait == 0);
        if (rx_wait > 0) rx_wait--;
        result_if.ready <= nxt_ready;
    end

    // long receiver hold-off so the block backs up into its input
    initial begin
        rx_hold = 1'b0;
        wait (beats_in >= HOLD_AFTER);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------

    initial begin
        stream_if.valid = 1'b0;
        stream_if.data  = '0;
        result_if.ready = 1'b0;

        // flush with all byte bits set
        push_beat(ACT_FLUSH, 8'hFF);
        // zero length, all-ones type, blank padded
        push_header(32'hFFFF_FFFF, {8'h20, 8'h20, 8'h20, 8'h30});
        // signed length is a header error
        push_header(32'h0000_0000, {8'h2B, 8'h31, 8'h46, 8'h20});
        // tab lead, trailing 0xA0 and 0x85, two payload bytes at the extremes
        push_header(32'h4162_4380, {8'h09, 8'h32, 8'hA0, 8'h85});
        push_beat(ACT_BYTE, 8'h00);
        push_beat(ACT_BYTE, 8'hFF);

        while (stream_q.size() < STREAM_BEATS) queue_message();
        stream_total = stream_q.size();

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beats_in < stream_total || deframed_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0)
            $display("text_message_deframer_unit_tb passed");
        else
            $display("text_message_deframer_unit_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tmd_pkg.sv
rtl/tmd_if.sv
rtl/text_message_deframer_unit.sv
tb/sv/text_message_deframer_unit_tb.sv
